// ===== rtl/core/eltwise_requant_mult_shift_defines.svh =====
// assertion macros for the element-wise requantization block
`ifndef ELTWISE_REQUANT_MULT_SHIFT_DEFINES_SVH
`define ELTWISE_REQUANT_MULT_SHIFT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ERQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ERQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next cycle check failed");
`else
`define ERQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ERQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/erq_pkg.sv =====
`timescale 1ns / 1ps
package erq_pkg;

    localparam int FRAC_W    = 52;
    localparam int SIG_W     = 53;
    localparam int EXP_W     = 11;
    localparam int EX_W      = 12;
    localparam int SHIFT_W   = 8;
    localparam int DIV_STEPS = 54;

    localparam logic [EXP_W-1:0] EXP_ALL_ONES = '1;

    localparam logic signed [EX_W-1:0] POST_LIMIT  = 12'sd128;
    localparam logic signed [EX_W-1:0] SHIFT_LIMIT = 12'sd255;
    localparam logic signed [EX_W-1:0] DIRECT_BIAS = 12'sd1022;
    localparam logic signed [EX_W-1:0] RECIP_BIAS  = 12'sd1023;
    localparam logic signed [EX_W-1:0] UNIT_BIAS   = 12'sd1024;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_POST  = 2'd1,
        ST_RANGE = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

endpackage

// ===== rtl/core/eltwise_requant_mult_shift.sv =====
`timescale 1ns / 1ps
`include "eltwise_requant_mult_shift_defines.svh"
// Requantization parameters for an element-wise sum: a triple of binary64 scales goes in on
// start and one result beat comes out on o_valid once the triple has passed every stage of the
// pipeline. A new triple is taken in every cycle and busy is always low; the receiver
// cannot stall, so results must be taken in the cycle they are shown. The pipeline computes the
// reciprocal of the output scale in a radix-2 restoring divider unrolled into 54 register stages,
// plus one decode stage in front, loaded by the accepting edge, and two stages behind it for the
// split checks and the shift alignment. legacy_post_shift_ok is read by items in flight, so
// the user must write it only while no item is in the pipeline; the block does not enforce it.
module eltwise_requant_mult_shift #(
    parameter int MULT_BITS      = 15,
    parameter int SHIFT_REG_BITS = 6,
    parameter int MULT_REG_BITS  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic                      i_cfg_wr_data,
    input  logic                      start,
    output logic                      busy,
    input  logic [63:0]               i_input1_scale,
    input  logic [63:0]               i_input2_scale,
    input  logic [63:0]               i_output_scale,
    output logic                      o_valid,
    output logic [MULT_REG_BITS-1:0]  o_in1_mult,
    output logic [MULT_REG_BITS-1:0]  o_in2_mult,
    output logic [MULT_BITS-1:0]      o_output_mult,
    output logic [SHIFT_REG_BITS-1:0] o_out_rshift,
    output logic signed [7:0]         o_input1_post_shift,
    output logic signed [7:0]         o_input2_post_shift,
    output logic signed [7:0]         o_output_post_shift,
    output erq_pkg::t_status          o_status
);
    import erq_pkg::*;

    localparam int LO_W = DIV_STEPS - MULT_BITS;
    localparam logic [31:0] MAX_MULT  = 32'((64'd1 << MULT_REG_BITS) - 64'd1);
    localparam logic [8:0]  MAX_SHIFT = 9'((1 << SHIFT_REG_BITS) - 1);
    localparam logic signed [EX_W-1:0] MB_S = EX_W'(MULT_BITS);

    typedef struct packed {
        logic                 bad;
        logic [MULT_BITS-1:0] mult;
        logic [SHIFT_W-1:0]   shift;
        logic [SHIFT_W-1:0]   post;
    } t_split;

    typedef struct packed {
        t_split           a1;
        t_split           a2;
        logic             o_bad;
        logic             o_zero;
        logic             o_one;
        logic [EXP_W-1:0] o_exp;
    } t_pay;

    function automatic t_split split_zero();
        t_split s;
        s.bad   = 1'b0;
        s.mult  = '0;
        s.shift = SHIFT_W'(MULT_BITS);
        s.post  = '0;
        return s;
    endfunction

    function automatic t_split split_value(input logic signed [EX_W-1:0] ex,
                                           input logic [MULT_BITS-1:0] m);
        t_split                  s;
        logic signed [EX_W-1:0]  d_hi;
        logic signed [EX_W-1:0]  d_lo;
        d_hi   = ex - MB_S;
        d_lo   = MB_S - ex;
        s.mult = m;
        if (ex > MB_S) begin
            s.bad   = (d_hi > POST_LIMIT);
            s.shift = '0;
            s.post  = SHIFT_W'(d_hi);
        end else begin
            s.bad   = (d_lo > SHIFT_LIMIT);
            s.shift = SHIFT_W'(d_lo);
            s.post  = '0;
        end
        return s;
    endfunction

    function automatic t_split split_direct(input logic [63:0] bits);
        t_split           s;
        logic [EXP_W-1:0] e;
        logic [SIG_W-1:0] sig;
        e   = bits[62:52];
        sig = {1'b1, bits[FRAC_W-1:0]};
        s   = split_value($signed({1'b0, e}) - DIRECT_BIAS, sig[SIG_W-1 -: MULT_BITS]);
        if (e == EXP_ALL_ONES) begin
            s.bad = 1'b1;
        end else if (e == '0 && bits[FRAC_W-1:0] == '0) begin
            s = split_zero();
        end else if (e == '0 || bits[63]) begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

    function automatic t_status post_check(input t_split s, input logic ok);
        t_status st;
        if (s.bad) begin
            st = ST_BAD;
        end else if (s.post != '0 && !ok) begin
            st = ST_POST;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

    logic r_legacy_post_shift_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_legacy_post_shift_ok <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_legacy_post_shift_ok <= i_cfg_wr_data;
        end
    end

    assign busy = 1'b0;

    // decode stage
    logic             r_dv_v   [DIV_STEPS+1];
    logic [SIG_W-1:0] r_dv_rem [DIV_STEPS+1];
    logic [FRAC_W-1:0] r_dv_f  [DIV_STEPS+1];
    logic [MULT_BITS-1:0] r_dv_q [DIV_STEPS+1];
    logic             r_dv_ones [DIV_STEPS+1];
    t_pay             r_dv_pay [DIV_STEPS+1];

    t_pay             n_pay;
    logic [EXP_W-1:0] w_oe;
    logic [FRAC_W-1:0] w_of;

    always_comb begin
        w_oe           = i_output_scale[62:52];
        w_of           = i_output_scale[FRAC_W-1:0];
        n_pay.a1       = split_direct(i_input1_scale);
        n_pay.a2       = split_direct(i_input2_scale);
        n_pay.o_zero   = (w_oe == EXP_ALL_ONES) && (w_of == '0);
        n_pay.o_bad    = (w_oe == EXP_ALL_ONES) ? (w_of != '0)
                                                : (w_oe == '0 || i_output_scale[63]);
        n_pay.o_one    = (w_of == '0);
        n_pay.o_exp    = w_oe;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= start;
        end
        r_dv_rem[0]  <= SIG_W'(1) << (SIG_W - 1);
        r_dv_f[0]    <= w_of;
        r_dv_q[0]    <= '0;
        r_dv_ones[0] <= 1'b1;
        r_dv_pay[0]  <= n_pay;
    end

    // reciprocal divider, one quotient bit a stage
    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_div
            logic [SIG_W:0]   w_two;
            logic [SIG_W+1:0] w_diff;
            logic             w_bit;
            logic [SIG_W-1:0] n_rem;

            assign w_two  = {r_dv_rem[k], 1'b0};
            assign w_diff = {1'b0, w_two} - {2'b01, r_dv_f[k]};
            assign w_bit  = ~w_diff[SIG_W+1];
            assign n_rem  = w_bit ? w_diff[SIG_W-1:0] : w_two[SIG_W-1:0];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_v[k+1] <= 1'b0;
                end else begin
                    r_dv_v[k+1] <= r_dv_v[k];
                end
                r_dv_rem[k+1] <= n_rem;
                r_dv_f[k+1]   <= r_dv_f[k];
                r_dv_pay[k+1] <= r_dv_pay[k];
                if (k < MULT_BITS) begin
                    r_dv_q[k+1]    <= {r_dv_q[k][MULT_BITS-2:0], w_bit};
                    r_dv_ones[k+1] <= r_dv_ones[k];
                end else begin
                    r_dv_q[k+1]    <= r_dv_q[k];
                    r_dv_ones[k+1] <= r_dv_ones[k] & w_bit;
                end
            end
        end
    endgenerate

    // output split and status
    t_pay                    w_dp;
    t_split                  n_ao;
    logic signed [EX_W-1:0]  w_oex;
    logic [MULT_BITS-1:0]    w_om;
    t_status                 n_st;

    always_comb begin
        w_dp  = r_dv_pay[DIV_STEPS];
        w_oex = w_dp.o_one ? (UNIT_BIAS - $signed({1'b0, w_dp.o_exp}))
                           : (RECIP_BIAS - $signed({1'b0, w_dp.o_exp}));
        w_om  = w_dp.o_one ? (MULT_BITS'(1) << (MULT_BITS - 1))
                           : (r_dv_q[DIV_STEPS] + MULT_BITS'(r_dv_ones[DIV_STEPS]));
        n_ao  = split_value(w_oex, w_om);
        if (w_dp.o_bad) begin
            n_ao.bad = 1'b1;
        end else if (w_dp.o_zero) begin
            n_ao = split_zero();
        end
        n_st = post_check(w_dp.a1, r_legacy_post_shift_ok);
        if (n_st == ST_OK) begin
            n_st = post_check(w_dp.a2, r_legacy_post_shift_ok);
        end
        if (n_st == ST_OK) begin
            n_st = post_check(n_ao, r_legacy_post_shift_ok);
        end
    end

    logic    r_b_v;
    t_split  r_b_a1;
    t_split  r_b_a2;
    t_split  r_b_ao;
    t_status r_b_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= r_dv_v[DIV_STEPS];
        end
        r_b_a1 <= w_dp.a1;
        r_b_a2 <= w_dp.a2;
        r_b_ao <= n_ao;
        r_b_st <= n_st;
    end

    // shift alignment
    logic [SHIFT_W-1:0] w_mn;
    logic [SHIFT_W-1:0] w_mx;
    logic [SHIFT_W-1:0] w_d1;
    logic [SHIFT_W-1:0] w_d2;
    logic [SHIFT_W-1:0] w_e1;
    logic [SHIFT_W-1:0] w_e2;
    logic [8:0]         w_sum_mx;
    logic [8:0]         w_sum_mn;
    logic               w_fit1;
    logic               w_fit2;
    logic [MULT_REG_BITS-1:0]  n_m1;
    logic [MULT_REG_BITS-1:0]  n_m2;
    logic [SHIFT_REG_BITS-1:0] n_osh;
    t_status                   n_ost;

    always_comb begin
        w_mn     = (r_b_a1.shift < r_b_a2.shift) ? r_b_a1.shift : r_b_a2.shift;
        w_mx     = (r_b_a1.shift < r_b_a2.shift) ? r_b_a2.shift : r_b_a1.shift;
        w_d1     = w_mx - r_b_a1.shift;
        w_d2     = w_mx - r_b_a2.shift;
        w_e1     = r_b_a1.shift - w_mn;
        w_e2     = r_b_a2.shift - w_mn;
        w_sum_mx = {1'b0, w_mx} + {1'b0, r_b_ao.shift};
        w_sum_mn = {1'b0, w_mn} + {1'b0, r_b_ao.shift};
        w_fit1   = 32'(r_b_a1.mult) <= (MAX_MULT >> w_d1);
        w_fit2   = 32'(r_b_a2.mult) <= (MAX_MULT >> w_d2);
        n_ost    = r_b_st;
        n_m1     = '0;
        n_m2     = '0;
        n_osh    = '0;
        if (r_b_st == ST_OK) begin
            if (w_sum_mx <= MAX_SHIFT && w_fit1 && w_fit2) begin
                n_m1  = MULT_REG_BITS'(32'(r_b_a1.mult) << w_d1);
                n_m2  = MULT_REG_BITS'(32'(r_b_a2.mult) << w_d2);
                n_osh = SHIFT_REG_BITS'(w_sum_mx);
            end else if (w_sum_mn < MAX_SHIFT) begin
                n_m1  = MULT_REG_BITS'(32'(r_b_a1.mult) >> w_e1);
                n_m2  = MULT_REG_BITS'(32'(r_b_a2.mult) >> w_e2);
                n_osh = SHIFT_REG_BITS'(w_sum_mn);
            end else begin
                n_ost = ST_RANGE;
            end
        end
    end

    logic                      r_valid;
    logic [MULT_REG_BITS-1:0]  r_m1;
    logic [MULT_REG_BITS-1:0]  r_m2;
    logic [MULT_BITS-1:0]      r_om;
    logic [SHIFT_REG_BITS-1:0] r_osh;
    logic [7:0]                r_p1;
    logic [7:0]                r_p2;
    logic [7:0]                r_po;
    t_status                   r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_b_v;
        end
        r_st <= n_ost;
        if (n_ost == ST_OK) begin
            r_m1  <= n_m1;
            r_m2  <= n_m2;
            r_om  <= r_b_ao.mult;
            r_osh <= n_osh;
            r_p1  <= 8'(-r_b_a1.post);
            r_p2  <= 8'(-r_b_a2.post);
            r_po  <= 8'(-r_b_ao.post);
        end else begin
            r_m1  <= '0;
            r_m2  <= '0;
            r_om  <= '0;
            r_osh <= '0;
            r_p1  <= '0;
            r_p2  <= '0;
            r_po  <= '0;
        end
    end

    assign o_valid             = r_valid;
    assign o_in1_mult          = r_m1;
    assign o_in2_mult          = r_m2;
    assign o_output_mult       = r_om;
    assign o_out_rshift        = r_osh;
    assign o_input1_post_shift = $signed(r_p1);
    assign o_input2_post_shift = $signed(r_p2);
    assign o_output_post_shift = $signed(r_po);
    assign o_status            = r_st;

    logic w_res_clear;
    logic w_post_clear;
    logic w_ok_no_legacy;

    assign w_res_clear    = (r_m1 == '0) && (r_m2 == '0) && (r_om == '0) && (r_osh == '0)
                            && (r_p1 == '0) && (r_p2 == '0) && (r_po == '0);
    assign w_post_clear   = (r_p1 == '0) && (r_p2 == '0) && (r_po == '0);
    assign w_ok_no_legacy = r_valid && (r_st == ST_OK) && !r_legacy_post_shift_ok;

    `ERQ_ASSERT_NEXT(a_beat_follows, i_clk, i_rst_n, r_b_v, r_valid)
    `ERQ_ASSERT_NEXT(a_no_stray_beat, i_clk, i_rst_n, !r_b_v, !r_valid)
    `ERQ_ASSERT_IMPLY(a_fail_clears, i_clk, i_rst_n, r_valid && r_st != ST_OK, w_res_clear)
    `ERQ_ASSERT_IMPLY(a_no_post_when_off, i_clk, i_rst_n, w_ok_no_legacy, w_post_clear)

endmodule
